FILE: rtl/pspwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pspwm_pkg;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [19:0] ERR_SAT_MAG = 20'd524288;
  localparam logic [19:0] ERR_FLOOR   = 20'd7;
  localparam logic [15:0] NO_LIMIT_MA = 16'hFFFF;

  // Shared divider geometry
  localparam int unsigned QUO_W = 37;
  localparam int unsigned REM_W = 20;
  localparam int unsigned ACC_W = 40;
  localparam logic [5:0] ERR_DIV_STEPS  = 6'd32;
  localparam logic [5:0] DAMP_DIV_STEPS = 6'd37;

  // Register map (word index)
  localparam logic [2:0] REG_FORCING_GAIN   = 3'd0;
  localparam logic [2:0] REG_DAMPING_GAIN   = 3'd1;
  localparam logic [2:0] REG_DAMPING_CUTOFF = 3'd2;
  localparam logic [2:0] REG_TRIP_TEMP_HIGH = 3'd3;
  localparam logic [2:0] REG_TRIP_TEMP_LOW  = 3'd4;
  localparam logic [2:0] REG_MIN_SUPPLY     = 3'd5;
  localparam logic [2:0] REG_MAX_SUPPLY     = 3'd6;
  localparam logic [2:0] REG_STARTUP_CURR   = 3'd7;

  typedef struct packed {
    logic [15:0] supply_mv;
    logic [15:0] sensed_rpm;
    logic [15:0] sensed_temp;
    logic [15:0] command_rpm;
    logic        enable;
    logic        power_fail;
    logic        supply_override_on;
    logic [15:0] supply_override_mv;
    logic        speed_override_on;
    logic [15:0] speed_override_rpm;
  } in_item_t;

  typedef struct packed {
    logic [16:0]        duty;
    logic signed [19:0] speed_error;
    logic [15:0]        drive_mv;
    logic               controller_powered;
    logic               motor_powered;
    logic               thermal_tripped;
    logic               in_startup;
    logic [15:0]        current_limit_ma;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR_DIV,
    S_ERR_FIX,
    S_FORCE_MUL,
    S_DAMP_MUL,
    S_DAMP_LOAD,
    S_DAMP_DIV,
    S_DAMP_ADD,
    S_CLAMP,
    S_DRIVE_MUL,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/pump_speed_pwm_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Pump motor PWM speed controller. One input transfer is one control tick and
// yields one result transfer. Supply window, power fault and thermal trip are
// evaluated when the tick is taken; when the motor runs with a nonzero command,
// the normalized speed error and the damping correction are formed on a single
// shared restoring divider (one quotient bit per cycle) next to one shared
// 20x17 multiplier, under a small sequencer. A running tick with damping goes
// through intake, the divider steps for the error and for the damping term,
// then multiply, add, clamp and output steps; without damping it skips the
// damping divide; an idle tick (motor off or command zero) goes from intake
// straight to the drive multiply and output. in_stall is high while a tick is
// in work. The result sits in an output register, so the next tick can be
// taken while it waits; a tick that finishes while the earlier result is still
// stalled holds in its last step until that result leaves. Configuration is an
// APB-style port, 32-bit words at byte address 4*index; pready is always high.
module pump_speed_pwm_controller (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire pspwm_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output pspwm_pkg::out_item_t       out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [4:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Configuration registers
  logic [16:0] forcing_gain;
  logic [16:0] damping_gain;
  logic [16:0] damping_cutoff;
  logic [15:0] trip_temperature_high;
  logic [15:0] trip_temperature_low;
  logic [15:0] min_supply_mv;
  logic [15:0] max_supply_mv;
  logic [15:0] startup_current_ma;

  // Loop state
  logic [16:0]        duty_reg;
  logic signed [19:0] error_reg;
  logic               trip_reg;
  logic               startup_reg;

  pspwm_pkg::state_t state, state_next;

  // Per-tick working registers
  logic [15:0] supply;
  logic        ctrl_on;
  logic        motor_on;
  logic        err_neg;
  logic [19:0] err_mag;
  logic signed [19:0] err_cur;
  logic        de_neg;
  logic [19:0] de_mag;
  logic signed [pspwm_pkg::ACC_W-1:0] acc;

  // Shared divider
  logic [pspwm_pkg::REM_W-1:0] div_rem;
  logic [pspwm_pkg::QUO_W-1:0] div_quo;
  logic [pspwm_pkg::REM_W-1:0] div_den;
  logic [5:0]                  div_cnt;
  logic [pspwm_pkg::REM_W:0]   rem_sh;
  logic                        rem_ge;
  logic [pspwm_pkg::REM_W:0]   rem_diff;

  // Shared multiplier
  logic [19:0] mul_a;
  logic [16:0] mul_b;
  logic [36:0] mul_p;

  // Sequencer outputs
  logic cfg_wr;
  logic in_take;
  logic div_step;
  logic out_load;

  // Input selection and power/trip evaluation
  logic [15:0] sel_supply;
  logic [15:0] sel_cmd;
  logic        ctrl_now;
  logic        trip_now;
  logic        motor_now;
  logic        run_now;
  logic [15:0] diff_mag;
  logic        diff_neg;

  always_comb begin
    sel_supply = in_data.supply_override_on ? in_data.supply_override_mv : in_data.supply_mv;
    sel_cmd    = in_data.speed_override_on ? in_data.speed_override_rpm : in_data.command_rpm;
    ctrl_now   = (sel_supply >= min_supply_mv) && (sel_supply <= max_supply_mv) &&
                 !in_data.power_fail;
    trip_now   = ctrl_now &&
                 ((in_data.sensed_temp > trip_temperature_high) || trip_reg) &&
                 !(in_data.sensed_temp < trip_temperature_low);
    motor_now  = ctrl_now && in_data.enable && !trip_now;
    run_now    = motor_now && (sel_cmd != 16'd0);
    diff_neg   = in_data.sensed_rpm > sel_cmd;
    diff_mag   = diff_neg ? (in_data.sensed_rpm - sel_cmd) : (sel_cmd - in_data.sensed_rpm);
  end

  // Divider step: shift one dividend bit into the remainder, trial subtract
  always_comb begin
    rem_sh   = {div_rem, div_quo[pspwm_pkg::QUO_W-1]};
    rem_ge   = rem_sh >= {1'b0, div_den};
    rem_diff = rem_sh - {1'b0, div_den};
  end

  // Error fix-up from the first quotient: sign, saturation, change of error
  logic [31:0]        q_err;
  logic [19:0]        fix_mag;
  logic signed [19:0] fix_err;
  logic signed [20:0] fix_de;

  always_comb begin
    q_err = div_quo[31:0];
    if (err_neg) begin
      fix_mag = (q_err > {12'd0, pspwm_pkg::ERR_SAT_MAG}) ? pspwm_pkg::ERR_SAT_MAG : q_err[19:0];
      fix_err = -$signed(fix_mag);
    end else begin
      fix_mag = q_err[19:0];
      fix_err = $signed(fix_mag);
    end
    fix_de = 21'(fix_err) - 21'(error_reg);
  end

  // Forcing term and damping term with sign, clamp of the accumulator
  logic signed [pspwm_pkg::ACC_W-1:0] force_term;
  logic signed [pspwm_pkg::ACC_W-1:0] damp_term;
  logic [16:0]                        duty_clamped;
  logic [19:0]                        damp_den;

  always_comb begin
    force_term = $signed({19'd0, mul_p[36:16]});
    if (err_neg) force_term = -force_term;
    damp_term = $signed({3'd0, div_quo});
    if (de_neg) damp_term = -damp_term;
    if (acc < 0) begin
      duty_clamped = 17'd0;
    end else if (acc > $signed({23'd0, pspwm_pkg::ONE_Q16})) begin
      duty_clamped = pspwm_pkg::ONE_Q16;
    end else begin
      duty_clamped = acc[16:0];
    end
    damp_den = (err_mag < pspwm_pkg::ERR_FLOOR) ? pspwm_pkg::ERR_FLOOR : err_mag;
  end

  // Sequencer outputs
  always_comb begin
    in_stall = (state != pspwm_pkg::S_IDLE);
    in_take  = in_valid && (state == pspwm_pkg::S_IDLE);
    div_step = (state == pspwm_pkg::S_ERR_DIV) || (state == pspwm_pkg::S_DAMP_DIV);
    out_load = (state == pspwm_pkg::S_DONE) && (!out_valid || !out_stall);
    cfg_wr   = psel && penable && pwrite && pready;
    case (state)
      pspwm_pkg::S_FORCE_MUL: begin
        mul_a = err_mag;
        mul_b = forcing_gain;
      end
      pspwm_pkg::S_DAMP_MUL: begin
        mul_a = de_mag;
        mul_b = damping_gain;
      end
      default: begin
        mul_a = {4'd0, supply};
        mul_b = duty_reg;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pspwm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = run_now ? pspwm_pkg::S_ERR_DIV : pspwm_pkg::S_DRIVE_MUL;
        end
      end
      pspwm_pkg::S_ERR_DIV: begin
        if (div_cnt == 6'd1) state_next = pspwm_pkg::S_ERR_FIX;
      end
      pspwm_pkg::S_ERR_FIX:   state_next = pspwm_pkg::S_FORCE_MUL;
      pspwm_pkg::S_FORCE_MUL: state_next = pspwm_pkg::S_DAMP_MUL;
      pspwm_pkg::S_DAMP_MUL: begin
        state_next = (err_mag > {3'd0, damping_cutoff}) ? pspwm_pkg::S_DAMP_LOAD
                                                        : pspwm_pkg::S_CLAMP;
      end
      pspwm_pkg::S_DAMP_LOAD: state_next = pspwm_pkg::S_DAMP_DIV;
      pspwm_pkg::S_DAMP_DIV: begin
        if (div_cnt == 6'd1) state_next = pspwm_pkg::S_DAMP_ADD;
      end
      pspwm_pkg::S_DAMP_ADD:  state_next = pspwm_pkg::S_CLAMP;
      pspwm_pkg::S_CLAMP:     state_next = pspwm_pkg::S_DRIVE_MUL;
      pspwm_pkg::S_DRIVE_MUL: state_next = pspwm_pkg::S_DONE;
      pspwm_pkg::S_DONE: begin
        if (out_load) state_next = pspwm_pkg::S_IDLE;
      end
      default: state_next = pspwm_pkg::S_IDLE;
    endcase
  end

  // Control state, loop state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= pspwm_pkg::S_IDLE;
      duty_reg              <= 17'd0;
      error_reg             <= 20'sd0;
      trip_reg              <= 1'b0;
      startup_reg           <= 1'b1;
      out_valid             <= 1'b0;
      div_cnt               <= 6'd0;
      forcing_gain          <= 17'd0;
      damping_gain          <= 17'd0;
      damping_cutoff        <= 17'd0;
      trip_temperature_high <= 16'hFFFF;
      trip_temperature_low  <= 16'd0;
      min_supply_mv         <= 16'd0;
      max_supply_mv         <= 16'hFFFF;
      startup_current_ma    <= 16'd0;
    end else begin
      state <= state_next;

      // Register write on the access cycle
      if (cfg_wr) begin
        case (paddr[4:2])
          pspwm_pkg::REG_FORCING_GAIN:   forcing_gain          <= pwdata[16:0];
          pspwm_pkg::REG_DAMPING_GAIN:   damping_gain          <= pwdata[16:0];
          pspwm_pkg::REG_DAMPING_CUTOFF: damping_cutoff        <= pwdata[16:0];
          pspwm_pkg::REG_TRIP_TEMP_HIGH: trip_temperature_high <= pwdata[15:0];
          pspwm_pkg::REG_TRIP_TEMP_LOW:  trip_temperature_low  <= pwdata[15:0];
          pspwm_pkg::REG_MIN_SUPPLY:     min_supply_mv         <= pwdata[15:0];
          pspwm_pkg::REG_MAX_SUPPLY:     max_supply_mv         <= pwdata[15:0];
          pspwm_pkg::REG_STARTUP_CURR:   startup_current_ma    <= pwdata[15:0];
          default: ;
        endcase
      end

      // Tick intake: trip update, idle tick resets the loop
      if (in_take) begin
        trip_reg <= trip_now;
        if (!run_now) begin
          duty_reg    <= 17'd0;
          error_reg   <= 20'sd0;
          startup_reg <= 1'b1;
        end
      end

      // Divider step counter
      if (in_take && run_now) begin
        div_cnt <= pspwm_pkg::ERR_DIV_STEPS;
      end else if (state == pspwm_pkg::S_DAMP_LOAD) begin
        div_cnt <= pspwm_pkg::DAMP_DIV_STEPS;
      end else if (div_step) begin
        div_cnt <= div_cnt - 6'd1;
      end

      if (state == pspwm_pkg::S_DAMP_MUL) begin
        error_reg <= err_cur;
        if (!(err_mag > {3'd0, damping_cutoff})) startup_reg <= 1'b0;
      end
      if (state == pspwm_pkg::S_CLAMP) duty_reg <= duty_clamped;

      // Result register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;

    if (in_take) begin
      supply   <= sel_supply;
      ctrl_on  <= ctrl_now;
      motor_on <= motor_now;
      err_neg  <= diff_neg;
      // Error dividend |cmd - rpm| << 16, left aligned for ERR_DIV_STEPS steps
      div_quo  <= {diff_mag, 16'd0, 5'd0};
      div_rem  <= '0;
      div_den  <= {4'd0, sel_cmd};
    end else if (state == pspwm_pkg::S_DAMP_LOAD) begin
      div_quo <= mul_p;
      div_rem <= '0;
      div_den <= damp_den;
    end else if (div_step) begin
      div_rem <= rem_ge ? rem_diff[pspwm_pkg::REM_W-1:0] : rem_sh[pspwm_pkg::REM_W-1:0];
      div_quo <= {div_quo[pspwm_pkg::QUO_W-2:0], rem_ge};
    end

    if (state == pspwm_pkg::S_ERR_FIX) begin
      err_mag <= fix_mag;
      err_cur <= fix_err;
      de_neg  <= fix_de[20];
      de_mag  <= fix_de[20] ? 20'(-fix_de) : fix_de[19:0];
    end

    // Accumulate old duty and forcing term, then damping term
    if (state == pspwm_pkg::S_DAMP_MUL) begin
      acc <= $signed({23'd0, duty_reg}) + force_term;
    end else if (state == pspwm_pkg::S_DAMP_ADD) begin
      acc <= acc + damp_term;
    end

    if (out_load) begin
      out_data.duty               <= duty_reg;
      out_data.speed_error        <= error_reg;
      out_data.drive_mv           <= mul_p[31:16];
      out_data.controller_powered <= ctrl_on;
      out_data.motor_powered      <= motor_on;
      out_data.thermal_tripped    <= trip_reg;
      out_data.in_startup         <= startup_reg;
      out_data.current_limit_ma   <= startup_reg ? startup_current_ma : pspwm_pkg::NO_LIMIT_MA;
    end
  end

  // Register readback
  always_comb begin
    pready = 1'b1;
    case (paddr[4:2])
      pspwm_pkg::REG_FORCING_GAIN:   prdata = {15'd0, forcing_gain};
      pspwm_pkg::REG_DAMPING_GAIN:   prdata = {15'd0, damping_gain};
      pspwm_pkg::REG_DAMPING_CUTOFF: prdata = {15'd0, damping_cutoff};
      pspwm_pkg::REG_TRIP_TEMP_HIGH: prdata = {16'd0, trip_temperature_high};
      pspwm_pkg::REG_TRIP_TEMP_LOW:  prdata = {16'd0, trip_temperature_low};
      pspwm_pkg::REG_MIN_SUPPLY:     prdata = {16'd0, min_supply_mv};
      pspwm_pkg::REG_MAX_SUPPLY:     prdata = {16'd0, max_supply_mv};
      pspwm_pkg::REG_STARTUP_CURR:   prdata = {16'd0, startup_current_ma};
      default:                       prdata = 32'd0;
    endcase
  end

  // Checks
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != pspwm_pkg::S_IDLE)
    else $error("tick taken but sequencer stayed idle");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    duty_reg <= pspwm_pkg::ONE_Q16)
    else $error("duty register above full scale");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == pspwm_pkg::S_ERR_DIV || state == pspwm_pkg::S_DAMP_DIV) |-> div_cnt != 6'd0)
    else $error("divider running with zero step count");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.motor_powered |->
      out_data.duty == 17'd0 && out_data.speed_error == 20'sd0 && out_data.in_startup)
    else $error("unpowered tick left loop state set");

  a_trip_power: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.thermal_tripped |-> out_data.controller_powered)
    else $error("thermal trip reported without controller power");

endmodule
`default_nettype wire

FILE: verif/pwm_tick_checker.sv
`timescale 1ns / 1ps
// Watches the tick and result channels and the register port of the pump speed
// controller, keeps its own copy of the control loop, and compares every result
// transfer with the oldest outstanding prediction.
module pwm_tick_checker
  import pspwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          results_due,
  output int          results_seen
);

  localparam longint UNITY         = 65536;
  localparam longint ERR_LO        = -524288;
  localparam longint ERR_HI        = 65536;
  localparam longint ERR_DIV_FLOOR = 7;

  // Register copies
  longint forcing_q16, damping_q16, cutoff_q16;
  longint temp_hi, temp_lo, supply_lo, supply_hi, startup_ma;

  // Loop state
  longint duty_now, err_now;
  bit     tripped, starting;

  out_item_t due_q[$];
  out_item_t oldest;

  function automatic longint bound(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One control tick: updates the loop state and returns the result it yields
  function automatic out_item_t control_tick(in_item_t t);
    longint    supply, cmd, temp, rpm, e, de, acc, mag, drive;
    bit        ctrl, motor;
    out_item_t r;
    supply = t.supply_override_on ? longint'(t.supply_override_mv) : longint'(t.supply_mv);
    cmd    = t.speed_override_on ? longint'(t.speed_override_rpm) : longint'(t.command_rpm);
    temp   = longint'(t.sensed_temp);
    rpm    = longint'(t.sensed_rpm);

    ctrl    = (supply >= supply_lo) && (supply <= supply_hi) && !t.power_fail;
    // hysteresis holds only while powered
    tripped = ctrl && ((temp > temp_hi) || tripped) && !(temp < temp_lo);
    motor   = ctrl && t.enable && !tripped;

    if (motor && cmd > 0) begin
      e   = bound((cmd - rpm) * UNITY / cmd, ERR_LO, ERR_HI);
      de  = e - err_now;
      acc = duty_now + e * forcing_q16 / UNITY;
      mag = (e < 0) ? -e : e;
      err_now = e;
      // damping above the cutoff, otherwise startup is over
      if (mag > cutoff_q16)
        acc += damping_q16 * de / ((mag < ERR_DIV_FLOOR) ? ERR_DIV_FLOOR : mag);
      else
        starting = 1'b0;
      duty_now = bound(acc, 0, UNITY);
    end else begin
      duty_now = 0;
      err_now  = 0;
      starting = 1'b1;
    end

    drive = (duty_now * supply) >> 16;
    r.duty               = 17'(duty_now);
    r.speed_error        = 20'(err_now);
    r.drive_mv           = 16'(drive);
    r.controller_powered = ctrl;
    r.motor_powered      = motor;
    r.thermal_tripped    = tripped;
    r.in_startup         = starting;
    r.current_limit_ma   = starting ? 16'(startup_ma) : NO_LIMIT_MA;
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      forcing_q16 = 0;
      damping_q16 = 0;
      cutoff_q16  = 0;
      temp_hi     = 65535;
      temp_lo     = 0;
      supply_lo   = 0;
      supply_hi   = 65535;
      startup_ma  = 0;
      duty_now    = 0;
      err_now     = 0;
      tripped     = 1'b0;
      starting    = 1'b1;
      due_q.delete();
      mismatch_count = 0;
      results_due    = 0;
      results_seen   = 0;
    end else begin
      // register writes land on the access cycle
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_FORCING_GAIN:   forcing_q16 = longint'(pwdata[16:0]);
          REG_DAMPING_GAIN:   damping_q16 = longint'(pwdata[16:0]);
          REG_DAMPING_CUTOFF: cutoff_q16  = longint'(pwdata[16:0]);
          REG_TRIP_TEMP_HIGH: temp_hi     = longint'(pwdata[15:0]);
          REG_TRIP_TEMP_LOW:  temp_lo     = longint'(pwdata[15:0]);
          REG_MIN_SUPPLY:     supply_lo   = longint'(pwdata[15:0]);
          REG_MAX_SUPPLY:     supply_hi   = longint'(pwdata[15:0]);
          default:            startup_ma  = longint'(pwdata[15:0]);
        endcase
      end

      if (in_valid && !in_stall)
        due_q.push_back(control_tick(in_data));

      // result transfer
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transfer with nothing outstanding, got %h", $time, out_data);
        end else begin
          oldest = due_q.pop_front();
          check_field("duty", 32'(oldest.duty), 32'(out_data.duty));
          check_field("speed_error", 32'(oldest.speed_error), 32'(out_data.speed_error));
          check_field("drive_mv", 32'(oldest.drive_mv), 32'(out_data.drive_mv));
          check_field("controller_powered", 32'(oldest.controller_powered),
                      32'(out_data.controller_powered));
          check_field("motor_powered", 32'(oldest.motor_powered),
                      32'(out_data.motor_powered));
          check_field("thermal_tripped", 32'(oldest.thermal_tripped),
                      32'(out_data.thermal_tripped));
          check_field("in_startup", 32'(oldest.in_startup), 32'(out_data.in_startup));
          check_field("current_limit_ma", 32'(oldest.current_limit_ma),
                      32'(out_data.current_limit_ma));
        end
      end
      results_due = due_q.size();
    end
  end

endmodule

FILE: verif/pump_speed_pwm_controller_test.sv
`timescale 1ns / 1ps
// Drives control ticks and register settings into the pump speed controller;
// the checker beside it predicts and compares every result.
module pump_speed_pwm_controller_test;
  import pspwm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  in_item_t    in_data;
  out_item_t   out_data;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  int mismatch_count, results_due, results_seen;
  int idle_pct, stall_pct, cycle_count, ticks_sent, settings_used;
  int unsigned cfg_now[8];

  pump_speed_pwm_controller uut (.*);
  pwm_tick_checker tick_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Presents one tick and returns at the edge where its transfer happens
  task automatic send_tick(in_item_t t);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // Writes all registers once the block is idle; upper data bits sometimes junk
  task automatic set_config(int unsigned fg, int unsigned dg, int unsigned co,
                            int unsigned hi, int unsigned lo, int unsigned mn,
                            int unsigned mx, int unsigned st);
    int          i;
    int unsigned w;
    logic [31:0] junk;
    cfg_now[REG_FORCING_GAIN]   = fg;
    cfg_now[REG_DAMPING_GAIN]   = dg;
    cfg_now[REG_DAMPING_CUTOFF] = co;
    cfg_now[REG_TRIP_TEMP_HIGH] = hi;
    cfg_now[REG_TRIP_TEMP_LOW]  = lo;
    cfg_now[REG_MIN_SUPPLY]     = mn;
    cfg_now[REG_MAX_SUPPLY]     = mx;
    cfg_now[REG_STARTUP_CURR]   = st;
    drain();
    for (i = 0; i < 8; i++) begin
      w    = (i <= int'(REG_DAMPING_CUTOFF)) ? 17 : 16;
      junk = ($urandom_range(1) == 1) ? ($urandom << w) : 32'd0;
      @(negedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {3'(i), 2'b00};
      pwdata  <= cfg_now[i] | junk;
      @(negedge clk);
      penable <= 1'b1;
      @(negedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
    settings_used++;
  endtask

  function automatic in_item_t tick(int unsigned supply, int unsigned rpm,
                                    int unsigned temp, int unsigned cmd, bit en,
                                    bit pf, bit so_on, int unsigned so_mv,
                                    bit sp_on, int unsigned sp_rpm);
    in_item_t t;
    t.supply_mv          = 16'(supply);
    t.sensed_rpm         = 16'(rpm);
    t.sensed_temp        = 16'(temp);
    t.command_rpm        = 16'(cmd);
    t.enable             = en;
    t.power_fail         = pf;
    t.supply_override_on = so_on;
    t.supply_override_mv = 16'(so_mv);
    t.speed_override_on  = sp_on;
    t.speed_override_rpm = 16'(sp_rpm);
    return t;
  endfunction

  function automatic in_item_t noise_tick();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[99:0];
  endfunction

  // Mostly in-window supply, temperature around the trip band and a sensed
  // speed close to the command, so the loop runs and startup can end
  function automatic in_item_t plausible_tick();
    in_item_t    t;
    int unsigned lo_mv, hi_mv, cmd, scale, pick;
    int          rpm;
    lo_mv = cfg_now[REG_MIN_SUPPLY];
    hi_mv = cfg_now[REG_MAX_SUPPLY];
    t.supply_mv  = 16'(($urandom_range(9) == 0) ? $urandom : $urandom_range(hi_mv, lo_mv));
    t.power_fail = ($urandom_range(19) == 0);
    t.enable     = ($urandom_range(9) != 0);

    pick = $urandom_range(9);
    if (pick == 0)
      t.sensed_temp = 16'($urandom_range(65535, cfg_now[REG_TRIP_TEMP_HIGH]));
    else if (pick == 1)
      t.sensed_temp = 16'($urandom_range(cfg_now[REG_TRIP_TEMP_LOW], 0));
    else
      t.sensed_temp = 16'($urandom_range(cfg_now[REG_TRIP_TEMP_HIGH],
                                         cfg_now[REG_TRIP_TEMP_LOW]));

    pick = $urandom_range(19);
    cmd  = (pick == 0) ? 0 : (pick < 4) ? $urandom_range(65535) : $urandom_range(6000, 100);
    t.command_rpm = 16'(cmd);
    // sensed speed within a random spread around the command
    scale = 1 << (4 * $urandom_range(4));
    rpm   = int'(cmd) + int'($urandom_range(scale)) - int'(scale / 2);
    if (rpm < 0) rpm = 0;
    if (rpm > 65535) rpm = 65535;
    t.sensed_rpm = 16'(rpm);

    t.supply_override_on = ($urandom_range(9) == 0);
    t.supply_override_mv = 16'(t.supply_override_on ? $urandom_range(hi_mv, lo_mv) : $urandom);
    t.speed_override_on  = ($urandom_range(9) == 0);
    t.speed_override_rpm = 16'($urandom_range(65535));
    return t;
  endfunction

  initial begin
    int          phase;
    int unsigned lo_t, hi_t, mn, mx;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    idle_pct  = 0;
    stall_pct = 0;
    rst       = 1'b1;
    cfg_now[REG_FORCING_GAIN]   = 0;
    cfg_now[REG_DAMPING_GAIN]   = 0;
    cfg_now[REG_DAMPING_CUTOFF] = 0;
    cfg_now[REG_TRIP_TEMP_HIGH] = 65535;
    cfg_now[REG_TRIP_TEMP_LOW]  = 0;
    cfg_now[REG_MIN_SUPPLY]     = 0;
    cfg_now[REG_MAX_SUPPLY]     = 65535;
    cfg_now[REG_STARTUP_CURR]   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: all-zero tick, then a running one
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick(65535, 0, 65535, 1000, 1, 0, 0, 0, 0, 0));

    set_config(32768, 16384, 0, 3500, 3000, 10000, 30000, 1500);
    // every field at its top value: supply outside the window
    send_tick(tick(65535, 65535, 65535, 65535, 1, 1, 1, 65535, 1, 65535));
    // full-scale error saturates at one, large overspeed at the negative floor
    send_tick(tick(24000, 0, 3100, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(24000, 65535, 3100, 1, 1, 0, 0, 0, 0, 0));
    send_tick(tick(24000, 2990, 3100, 3000, 1, 0, 0, 0, 0, 0));
    // zero error ends startup; a one-count error divides by the floor
    send_tick(tick(24000, 3000, 3100, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(24000, 65534, 3100, 65535, 1, 0, 0, 0, 0, 0));
    // window edges are inclusive
    send_tick(tick(10000, 2000, 3100, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(30000, 2000, 3100, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(9999, 2000, 3100, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(30001, 2000, 3100, 3000, 1, 0, 0, 0, 0, 0));
    // supply override in and out of the window
    send_tick(tick(5000, 2500, 3100, 3000, 1, 0, 1, 20000, 0, 0));
    send_tick(tick(20000, 2500, 3100, 3000, 1, 0, 1, 40000, 0, 0));
    // speed override of zero idles; override with zero command runs
    send_tick(tick(20000, 2500, 3100, 3000, 1, 0, 0, 0, 1, 0));
    send_tick(tick(20000, 2500, 3100, 0, 1, 0, 0, 0, 1, 4000));
    // power fault, motor disabled
    send_tick(tick(20000, 2500, 3100, 3000, 1, 1, 0, 0, 0, 0));
    send_tick(tick(20000, 2500, 3100, 3000, 0, 0, 0, 0, 0, 0));
    // trip, hold inside the band, clear below it, trip again, lose power
    send_tick(tick(20000, 2500, 3600, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(20000, 2500, 3200, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(20000, 2500, 2900, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(20000, 2500, 3600, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(5000, 2500, 3200, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(20000, 2500, 3200, 3000, 1, 0, 0, 0, 0, 0));
    send_tick(tick(20000, 2500, 0, 3000, 1, 0, 0, 0, 0, 0));

    // random phases, each under its own settings and idling pattern
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(65536, 65536, 65536, 65535, 0, 0, 65535, 65534);
        1: set_config(0, 0, 0, 0, 0, 0, 0, 0);
        2: set_config(20000, 8000, 2000, 3500, 3200, 20000, 32000, 2500);
        // inverted trip band, gains above unity, tiny cutoff
        3: set_config(90000, 131071, 5, 1000, 5000, 0, 65535, 100);
        // empty supply window
        4: set_config(30000, 30000, 1000, 3500, 3000, 40000, 30000, 777);
        default: begin
          lo_t = $urandom_range(4000, 2000);
          hi_t = lo_t + $urandom_range(1000);
          mn   = $urandom_range(30000);
          mx   = mn + $urandom_range(30000);
          set_config(($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(65536),
                     ($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(65536),
                     ($urandom_range(3) == 0) ? $urandom_range(10) : $urandom_range(20000),
                     hi_t, lo_t, mn, mx, $urandom_range(65534));
        end
      endcase
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      repeat ((phase == 4) ? 100 : 215)
        send_tick(($urandom_range(4) == 0) ? noise_tick() : plausible_tick());
    end

    drain();
    repeat (100) @(negedge clk);
    $display("%0d control ticks sent, %0d results compared, %0d register settings",
             ticks_sent, results_seen, settings_used);
    $display("covered window edges, trip hysteresis, error saturation and sender/receiver idling");
    if (mismatch_count == 0 && results_due == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
